// ----- rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, constants and control types of the modular exponentiation
// block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // field widths
  localparam int unsigned ModW = 32;
  localparam int unsigned ValW = 63;

  // step counter covers the longest pass (one step per base bit)
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] RedSteps = CntW'(ValW);
  localparam logic [CntW-1:0] MulSteps = CntW'(ModW);

  // modulus after reset
  localparam logic [ModW-1:0] ModulusReset = 32'd1000000007;

  // operation codes
  localparam logic OpPower   = 1'b0;
  localparam logic OpInverse = 1'b1;

  // request from the sequencer to the step unit
  typedef struct packed {
    logic start;   // load operands and begin a pass
    logic reduce;  // 1: reduce the 63-bit operand, 0: modular multiply
  } mexp_req_t;

endpackage

// ----- rtl/mexp_in_if.sv -----
// ----------------------------------------------------------------------------
// mexp_in_if
// Input channel: one word per exponentiation request.
// ----------------------------------------------------------------------------
interface mexp_in_if import mexp_pkg::*; ();

  logic            valid;
  logic            ready;
  logic            operation;
  logic [ValW-1:0] base;
  logic [ValW-1:0] exponent;

  modport source (output valid, output operation, output base, output exponent, input ready);
  modport sink   (input valid, input operation, input base, input exponent, output ready);

endinterface

// ----- rtl/mexp_out_if.sv -----
// ----------------------------------------------------------------------------
// mexp_out_if
// Output channel: one result word per request.
// ----------------------------------------------------------------------------
interface mexp_out_if import mexp_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [ModW-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);

endinterface

// ----- rtl/mexp_modmul.sv -----
// ----------------------------------------------------------------------------
// mexp_modmul
// Shared shift-add-reduce unit. Each cycle it forms r = 2r + addend and
// brings it back below the modulus. A multiply pass walks the 32 bits of
// one factor (addend is the other factor or zero); a reduce pass walks the
// 63 bits of the base (addend is the bit itself).
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mexp_req_t       req_i,
  input  logic [ModW-1:0] x_i,
  input  logic [ValW-1:0] y_i,
  input  logic [ModW-1:0] mod_i,
  output logic            done_o,
  output logic [ModW-1:0] res_o
);

  logic            busy_q;
  logic            done_q;
  logic            reduce_q;
  logic [CntW-1:0] cnt_q;
  logic [ValW-1:0] sh_q;
  logic [ModW-1:0] r_q;
  logic [ModW-1:0] r_d;

  logic [ModW+1:0] addend;
  logic [ModW+1:0] sum;
  logic [ModW+1:0] mod1;
  logic [ModW+1:0] mod2;
  logic [ModW+1:0] sub1;
  logic [ModW+1:0] sub2;

  // one step: double, add, subtract the modulus up to twice
  always_comb begin
    if (reduce_q) begin
      addend = {{(ModW+1){1'b0}}, sh_q[ValW-1]};
    end else if (sh_q[ValW-1]) begin
      addend = {2'b00, x_i};
    end else begin
      addend = '0;
    end
    sum  = {1'b0, r_q, 1'b0} + addend;
    mod1 = {2'b00, mod_i};
    mod2 = {1'b0, mod_i, 1'b0};
    sub1 = sum - mod1;
    sub2 = sum - mod2;
    if (sum >= mod2) begin
      r_d = sub2[ModW-1:0];
    end else if (sum >= mod1) begin
      r_d = sub1[ModW-1:0];
    end else begin
      r_d = sum[ModW-1:0];
    end
  end

  // pass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      reduce_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        reduce_q <= req_i.reduce;
        cnt_q    <= req_i.reduce ? RedSteps : MulSteps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand shifter and partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      if (req_i.reduce) begin
        sh_q <= y_i;
      end else begin
        sh_q <= {y_i[ModW-1:0], {(ValW-ModW){1'b0}}};
      end
    end else if (busy_q) begin
      r_q  <= r_d;
      sh_q <= {sh_q[ValW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ----- rtl/mexp_seq.sv -----
// ----------------------------------------------------------------------------
// mexp_seq
// Square-and-multiply sequencer. Holds base, running result and exponent,
// walks the exponent from the low bit up and issues reduce, multiply and
// square passes to the shared step unit.
// ----------------------------------------------------------------------------
module mexp_seq import mexp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  mexp_in_if.sink         in_i,
  input  logic [ModW-1:0] mod_i,
  input  logic            unit_done_i,
  input  logic [ModW-1:0] unit_res_i,
  output mexp_req_t       req_o,
  output logic [ModW-1:0] x_o,
  output logic [ValW-1:0] y_o,
  input  logic            out_free_i,
  output logic            fin_o,
  output logic [ModW-1:0] res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBase = 3'd1;
  localparam logic [2:0] StNext = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StSqr  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]      st_q, st_d;
  logic [ModW-1:0] base_q, base_d;
  logic [ModW-1:0] acc_q, acc_d;
  logic [ValW-1:0] exp_q, exp_d;
  logic [ModW-1:0] mod_m2;
  logic [ModW-1:0] y_reg;
  logic            accept;

  assign in_i.ready = (st_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign mod_m2     = mod_i - ModW'(2);

  // operands for the step unit: y is sampled when a pass starts, x is read on every step
  assign y_reg = ((st_q == StNext) && exp_q[0]) ? acc_q : base_q;
  assign y_o   = (st_q == StIdle) ? in_i.base : {{(ValW-ModW){1'b0}}, y_reg};
  assign x_o   = base_q;
  assign res_o = acc_q;

  // next state and pass requests
  always_comb begin
    st_d         = st_q;
    base_d       = base_q;
    acc_d        = acc_q;
    exp_d        = exp_q;
    req_o.start  = 1'b0;
    req_o.reduce = 1'b0;
    fin_o        = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          if (mod_i < ModW'(2)) begin
            acc_d = '0;
            st_d  = StDone;
          end else begin
            acc_d        = ModW'(1);
            exp_d        = (in_i.operation == OpInverse) ?
                           {{(ValW-ModW){1'b0}}, mod_m2} : in_i.exponent;
            req_o.start  = 1'b1;
            req_o.reduce = 1'b1;
            st_d         = StBase;
          end
        end
      end
      StBase: begin
        if (unit_done_i) begin
          base_d = unit_res_i;
          st_d   = StNext;
        end
      end
      StNext: begin
        if (exp_q == '0) begin
          st_d = StDone;
        end else begin
          req_o.start = 1'b1;
          st_d        = exp_q[0] ? StMul : StSqr;
        end
      end
      StMul: begin
        if (unit_done_i) begin
          acc_d = unit_res_i;
          // no square needed after the top exponent bit
          if (exp_q[ValW-1:1] == '0) begin
            st_d = StDone;
          end else begin
            req_o.start = 1'b1;
            st_d        = StSqr;
          end
        end
      end
      StSqr: begin
        if (unit_done_i) begin
          base_d = unit_res_i;
          exp_d  = {1'b0, exp_q[ValW-1:1]};
          st_d   = StNext;
        end
      end
      StDone: begin
        if (out_free_i) begin
          fin_o = 1'b1;
          st_d  = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
  end

endmodule

// ----- rtl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// or base^(modulus-2) mod modulus in inverse mode, on one shared
// shift-add-reduce unit.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    operation, base, exponent
//   out_o     out   valid/ready    result
//   cfg       in    cfg_we_i       cfg_wdata_i (modulus)
//
// One word at a time: in_i.ready is high only while the sequencer is idle.
// From accept to result: the base is reduced, then each exponent bit below
// the top set bit takes a multiply pass if set and then a square pass, and
// the top bit takes a multiply pass only; a zero exponent needs only the
// reduce pass, and a modulus below 2 gives its result without any pass.
// The shared unit handles one operand bit per cycle.
// The result sits in an output register; a stalled output holds the block in
// its finish state. Reset sets the modulus to 1000000007 and the block idle.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ModW-1:0] cfg_wdata_i,
  mexp_in_if.sink         in_i,
  mexp_out_if.source      out_o
);

  logic [ModW-1:0] modulus_q;
  logic            out_valid_q;
  logic [ModW-1:0] out_res_q;
  logic            out_free;

  mexp_req_t       req;
  logic [ModW-1:0] x_op;
  logic [ValW-1:0] y_op;
  logic            unit_done;
  logic [ModW-1:0] unit_res;
  logic            fin;
  logic [ModW-1:0] seq_res;

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // sequencer
  mexp_seq u_mexp_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mod_i       (modulus_q),
    .unit_done_i (unit_done),
    .unit_res_i  (unit_res),
    .req_o       (req),
    .x_o         (x_op),
    .y_o         (y_op),
    .out_free_i  (out_free),
    .fin_o       (fin),
    .res_o       (seq_res)
  );

  // shared step unit
  mexp_modmul u_mexp_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .x_i    (x_op),
    .y_i    (y_op),
    .mod_i  (modulus_q),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  // output register
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_res_q <= seq_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_res_q;

endmodule

// ----- rtl/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker import mexp_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [ModW-1:0] out_result_i
);

  // a pending word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // a stalled word keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_result_i))
    else $error("output word changed while stalled");

  // one word in flight: no second accept right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // a result cannot appear in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result)
);
